// File: sv/spac_pkg.sv
// Shared codes, field layout and widths for the shadow poison access checker.
package spac_pkg;

    // Operation codes carried in the slave-side tuser
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_POISON = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Slave-side tdata layout
    localparam int S_ADDR_LSB = 0;
    localparam int S_SIZE_LSB = 32;
    localparam int S_WR_BIT   = 35;

    // Master-side tdata layout
    localparam int M_VIOL_BIT  = 0;
    localparam int M_OOR_BIT   = 1;
    localparam int M_ADDR_LSB  = 2;
    localparam int M_SIZE_LSB  = 34;
    localparam int M_WR_BIT    = 37;
    localparam int M_USED_MSB  = 37;

endpackage

// File: sv/spac_ram.sv
// Generic simple dual-port RAM with registered read data.
module spac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/shadow_poison_access_checker.sv
// Top level: shadow bitmap poison/clear/check engine over two banked RAMs.
//
// Usage
//   Slave channel carries one operation per transfer: tuser selects check,
//   poison or clear; tdata carries address, access size and direction.
//   Master channel returns exactly one result per operation: violation,
//   out-of-range flag and, with a violation, the faulting access.
//   Write region_base via i_cfg_we/i_cfg_wdata only while idle (unchecked).
// Timing
//   Each operation has an accept cycle, which issues the shadow read, then
//   S_EVAL, which tests or modifies the bits and loads the output register.
//   The result shows on the master side from that register once S_EVAL ends.
//   The read-modify-write of a shadow byte sets the rate: no new transfer
//   is taken until the previous operation has left S_EVAL.
// Reset
//   After reset the block sweeps both shadow banks to all-poisoned, one
//   row per cycle, REGION_BYTES/16 (rounded up) rows; o_s_tready stays low.
// Stall
//   A held result keeps the evaluating operation parked (RAM output held)
//   and no new transfer is accepted until the output register frees up.
module shadow_poison_access_checker #(
    parameter int REGION_BYTES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config
    input  logic                         i_cfg_we,
    input  logic [spac_pkg::ADDR_W-1:0]  i_cfg_wdata,  // region_base
    // slave side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [31:0] address, [34:32] access_size, [35] is_write, [39:36] zero
    input  logic [spac_pkg::S_DATA_W-1:0] i_s_tdata,
    // [1:0] op
    input  logic [spac_pkg::OP_W-1:0]    i_s_tuser,
    // master side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [0] violation, [1] out_of_range, [33:2] fault_address,
    // [36:34] fault_size, [37] fault_is_write, [39:38] zero
    output logic [spac_pkg::M_DATA_W-1:0] o_m_tdata
);

    // Map geometry: even map bytes in bank 0, odd in bank 1
    localparam int MAP_DEPTH  = (REGION_BYTES + 7) / 8;
    localparam int IDX_W      = $clog2(MAP_DEPTH);
    localparam int BANK_DEPTH = (MAP_DEPTH + 1) / 2;
    localparam int AW         = IDX_W - 1;
    localparam int AWD        = spac_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [AWD-1:0]              r_region_base;
    logic [AW-1:0]               r_sweep_addr, n_sweep_addr;

    // captured item
    logic [spac_pkg::OP_W-1:0]   r_op;
    logic [AWD-1:0]              r_offset;
    logic [AWD-1:0]              r_address;
    logic [spac_pkg::SIZE_W-1:0] r_size;
    logic                        r_is_write;

    logic                        r_m_tvalid;
    logic [spac_pkg::M_DATA_W-1:0] r_m_tdata, n_m_tdata;

    // accept-side decode
    logic                        s_accept;
    logic [AWD-1:0]              s_address;
    logic [spac_pkg::SIZE_W-1:0] s_size_raw, s_size;
    logic [AWD-1:0]              s_offset;
    logic [IDX_W-1:0]            s_idx;
    logic [AW-1:0]               s_row;

    // eval-side
    logic                        e_advance;
    logic [IDX_W-1:0]            e_idx;
    logic [AW-1:0]               e_row;
    logic [spac_pkg::SIZE_W-1:0] e_span;
    logic [AWD:0]                e_last;
    logic                        e_inside;
    logic [7:0]                  e_lo, e_hi;
    logic [3:0]                  e_mask4;
    logic [15:0]                 e_mask;
    logic [7:0]                  e_bit, e_new;
    logic                        e_mark, e_viol, e_oor;

    // RAM ports
    logic                        even_we, odd_we, ram_re;
    logic [AW-1:0]               even_waddr, odd_waddr, even_raddr, odd_raddr;
    logic [7:0]                  even_wdata, odd_wdata, even_q, odd_q;

    assign s_accept   = i_s_tvalid && (r_state == S_IDLE);
    assign s_address  = i_s_tdata[spac_pkg::S_ADDR_LSB +: AWD];
    assign s_size_raw = i_s_tdata[spac_pkg::S_SIZE_LSB +: spac_pkg::SIZE_W];
    assign s_offset   = s_address - r_region_base;
    assign s_idx      = s_offset[3 +: IDX_W];
    assign s_row      = s_idx[IDX_W-1:1];

    // size 0 acts as 1, sizes above 4 act as 4
    always_comb begin
        case (s_size_raw) inside
            3'd0:                s_size = 3'd1;
            [3'd1:3'd3]:         s_size = s_size_raw;
            default:             s_size = 3'd4;
        endcase
    end

    // Read both banks: the map byte holding the first byte and the next one.
    assign ram_re     = s_accept;
    assign odd_raddr  = s_row;
    assign even_raddr = s_idx[0] ? s_row + AW'(1) : s_row;

    // ---------------- evaluate ----------------
    assign e_advance = (r_state == S_EVAL) && (!r_m_tvalid || i_m_tready);
    assign e_idx     = r_offset[3 +: IDX_W];
    assign e_row     = e_idx[IDX_W-1:1];
    // a mark covers one byte whatever the size field says
    assign e_span    = (r_op == spac_pkg::OP_CHECK) ? r_size : 3'd1;
    assign e_last    = {1'b0, r_offset} + (AWD+1)'(e_span) - (AWD+1)'(1);
    assign e_inside  = e_last < (AWD+1)'(REGION_BYTES);

    assign e_lo = e_idx[0] ? odd_q  : even_q;
    assign e_hi = e_idx[0] ? even_q : odd_q;

    always_comb begin
        case (r_size)
            3'd1:    e_mask4 = 4'b0001;
            3'd2:    e_mask4 = 4'b0011;
            3'd3:    e_mask4 = 4'b0111;
            default: e_mask4 = 4'b1111;
        endcase
    end

    // access bits may spill into the next map byte
    assign e_mask = {12'd0, e_mask4} << r_offset[2:0];
    assign e_bit  = 8'd1 << r_offset[2:0];
    assign e_new  = (r_op == spac_pkg::OP_POISON) ? (e_lo | e_bit) : (e_lo & ~e_bit);

    always_comb begin
        e_viol = 1'b0;
        e_oor  = 1'b0;
        e_mark = 1'b0;
        case (r_op) inside
            spac_pkg::OP_CHECK: begin
                e_oor  = !e_inside;
                e_viol = e_inside && (|({e_hi, e_lo} & e_mask));
            end
            spac_pkg::OP_POISON, spac_pkg::OP_CLEAR: begin
                e_oor  = !e_inside;
                e_mark = e_inside;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_m_tdata = '0;
        n_m_tdata[spac_pkg::M_VIOL_BIT] = e_viol;
        n_m_tdata[spac_pkg::M_OOR_BIT]  = e_oor;
        if (e_viol) begin
            n_m_tdata[spac_pkg::M_ADDR_LSB +: AWD]             = r_address;
            n_m_tdata[spac_pkg::M_SIZE_LSB +: spac_pkg::SIZE_W] = r_size;
            n_m_tdata[spac_pkg::M_WR_BIT]                      = r_is_write;
        end
    end

    // Write side: sweep fills both banks; a mark writes back its own bank.
    always_comb begin
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_waddr = e_row;
        odd_waddr  = e_row;
        even_wdata = e_new;
        odd_wdata  = e_new;
        if (r_state == S_SWEEP) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = r_sweep_addr;
            odd_waddr  = r_sweep_addr;
            even_wdata = 8'hFF;
            odd_wdata  = 8'hFF;
        end else if (e_advance && e_mark) begin
            even_we = !e_idx[0];
            odd_we  = e_idx[0];
        end
    end

    // ---------------- control ----------------
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        unique case (r_state)
            S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(BANK_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (e_advance) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_sweep_addr  <= '0;
            r_region_base <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            if (i_cfg_we) begin
                r_region_base <= i_cfg_wdata;
            end
            if (e_advance) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op       <= i_s_tuser;
            r_offset   <= s_offset;
            r_address  <= s_address;
            r_size     <= s_size;
            r_is_write <= i_s_tdata[spac_pkg::S_WR_BIT];
        end
        if (e_advance) begin
            r_m_tdata <= n_m_tdata;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    spac_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_waddr (even_waddr),
        .i_wdata (even_wdata),
        .i_re    (ram_re),
        .i_raddr (even_raddr),
        .o_rdata (even_q)
    );

    spac_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_waddr (odd_waddr),
        .i_wdata (odd_wdata),
        .i_re    (ram_re),
        .i_raddr (odd_raddr),
        .o_rdata (odd_q)
    );

endmodule

// File: sv/spac_checker.sv
// Port-level assertions for the shadow poison access checker, bound to the top.
module spac_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [spac_pkg::M_DATA_W-1:0] o_m_tdata
);

    // one transfer in flight: no accept on back-to-back edges
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("accept on consecutive cycles");

    // fault fields are zero unless a violation is flagged
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[spac_pkg::M_VIOL_BIT])
        |-> (o_m_tdata[spac_pkg::M_USED_MSB:spac_pkg::M_ADDR_LSB] == '0))
        else $error("fault fields set without violation");

    // a violation is never out of range, and its size is 1 to 4
    a_viol_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[spac_pkg::M_VIOL_BIT])
        |-> (!o_m_tdata[spac_pkg::M_OOR_BIT]
             && (o_m_tdata[spac_pkg::M_SIZE_LSB +: spac_pkg::SIZE_W] != 3'd0)
             && (o_m_tdata[spac_pkg::M_SIZE_LSB +: spac_pkg::SIZE_W] <= 3'd4)))
        else $error("bad violation fields");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed under stall");

endmodule

bind shadow_poison_access_checker spac_checker u_spac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: sim/shadow_poison_access_checker_tb.sv
// Self-checking testbench for the shadow poison access checker.
module shadow_poison_access_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGION_BYTES   = 65536;
    // Op code the block must treat as a no-op with an all-zero result
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Outlasts the reset sweep, which holds tready low while it runs
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic                        violation;
        logic                        out_of_range;
        logic [spac_pkg::ADDR_W-1:0] fault_address;
        logic [spac_pkg::SIZE_W-1:0] fault_size;
        logic                        fault_is_write;
    } t_access_verdict;

    // Tracks the shadow bitmap and the verdicts still owed by the block.
    class t_poison_shadow_tracker;
        bit                          poisoned[REGION_BYTES];
        logic [spac_pkg::ADDR_W-1:0] region_base;
        t_access_verdict             owed_verdicts[$];
        int                          fail_count;

        function new();
            foreach (poisoned[i]) poisoned[i] = 1'b1;
            region_base = '0;
            fail_count  = 0;
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction

        // Apply one accepted transfer to the bitmap and queue its verdict.
        function void accept_op(input logic [1:0] op,
                                input logic [spac_pkg::ADDR_W-1:0] addr,
                                input logic [spac_pkg::SIZE_W-1:0] size, input logic wr);
            t_access_verdict             v;
            logic [spac_pkg::ADDR_W-1:0] offset;
            logic [spac_pkg::SIZE_W-1:0] eff;
            logic [spac_pkg::ADDR_W:0]   last;
            v      = '0;
            offset = addr - region_base;
            eff    = (size == 0) ? 3'd1 : (size > 4) ? 3'd4 : size;
            last   = {1'b0, offset} + eff - 1;
            case (op) inside
                spac_pkg::OP_CHECK: begin
                    if (last >= REGION_BYTES) begin
                        v.out_of_range = 1'b1;
                    end else begin
                        for (int i = 0; i < eff; i++)
                            if (poisoned[offset + i]) v.violation = 1'b1;
                    end
                end
                spac_pkg::OP_POISON, spac_pkg::OP_CLEAR: begin
                    if (offset >= REGION_BYTES) v.out_of_range = 1'b1;
                    else poisoned[offset] = (op == spac_pkg::OP_POISON);
                end
                default: ;
            endcase
            if (v.violation) begin
                v.fault_address  = addr;
                v.fault_size     = eff;
                v.fault_is_write = wr;
            end
            owed_verdicts.push_back(v);
        endfunction

        // Compare one master-side transfer with the oldest owed verdict.
        function void check_result(input logic [spac_pkg::M_DATA_W-1:0] tdata);
            t_access_verdict want;
            t_access_verdict got;
            if (owed_verdicts.size() == 0) begin
                $error("unexpected result transfer, tdata %h", tdata);
                fail_count++;
                return;
            end
            want = owed_verdicts.pop_front();
            got.violation      = tdata[spac_pkg::M_VIOL_BIT];
            got.out_of_range   = tdata[spac_pkg::M_OOR_BIT];
            got.fault_address  = tdata[spac_pkg::M_ADDR_LSB +: spac_pkg::ADDR_W];
            got.fault_size     = tdata[spac_pkg::M_SIZE_LSB +: spac_pkg::SIZE_W];
            got.fault_is_write = tdata[spac_pkg::M_WR_BIT];
            if (got.violation !== want.violation) begin
                $error("violation: expected %0h, actual %0h", want.violation, got.violation);
                fail_count++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $error("out_of_range: expected %0h, actual %0h",
                       want.out_of_range, got.out_of_range);
                fail_count++;
            end
            if (got.fault_address !== want.fault_address) begin
                $error("fault_address: expected %0h, actual %0h",
                       want.fault_address, got.fault_address);
                fail_count++;
            end
            if (got.fault_size !== want.fault_size) begin
                $error("fault_size: expected %0h, actual %0h",
                       want.fault_size, got.fault_size);
                fail_count++;
            end
            if (got.fault_is_write !== want.fault_is_write) begin
                $error("fault_is_write: expected %0h, actual %0h",
                       want.fault_is_write, got.fault_is_write);
                fail_count++;
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [spac_pkg::ADDR_W-1:0]   i_cfg_wdata = '0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    // [31:0] address, [34:32] size, [35] is_write
    logic [spac_pkg::S_DATA_W-1:0] i_s_tdata   = '0;
    logic [spac_pkg::OP_W-1:0]     i_s_tuser   = '0;   // [1:0] op
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    // [0] viol, [1] oor, [33:2] addr, [36:34] size, [37] wr
    logic [spac_pkg::M_DATA_W-1:0] o_m_tdata;

    t_poison_shadow_tracker tracker;
    int src_idle_pct  = 0;    // chance per cycle that the sender holds off
    int sink_idle_pct = 0;    // chance per cycle that the receiver stalls
    int idle_cycles   = 0;
    int win_offset    = 0;    // current hot window inside the region

    shadow_poison_access_checker #(
        .REGION_BYTES(REGION_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: check each result transfer, then pick the next cycle's tready.
    // Values read here are the ones in effect at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready && tracker != null)
            tracker.check_result(o_m_tdata);
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: give up after a long run of cycles with no transfer anywhere.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** shadow_poison_access_checker: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one operation, with random hold-off first; returns at the accept edge.
    // tvalid stays high into the next call when no gap is drawn.
    task automatic push_op(input logic [1:0] op, input logic [spac_pkg::ADDR_W-1:0] addr,
                           input logic [spac_pkg::SIZE_W-1:0] size, input logic wr);
        logic [spac_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[spac_pkg::S_ADDR_LSB +: spac_pkg::ADDR_W] = addr;
        d[spac_pkg::S_SIZE_LSB +: spac_pkg::SIZE_W] = size;
        d[spac_pkg::S_WR_BIT]                       = wr;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        tracker.accept_op(op, addr, size, wr);
    endtask

    // Drain everything in flight, let the pipe settle, then write region_base.
    task automatic write_region_base(input logic [spac_pkg::ADDR_W-1:0] base);
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.region_base = base;
    endtask

    // Boundary and corner cases, with region_base at 0.
    task automatic run_directed();
        push_op(spac_pkg::OP_CHECK, 32'd0, 3'd1, 1'b0);            // map starts all poisoned
        for (int a = 4; a < 10; a++) push_op(spac_pkg::OP_CLEAR, a, 3'd1, 1'b0);
        push_op(spac_pkg::OP_CHECK, 32'd4, 3'd4, 1'b1);            // clean, one shadow byte
        push_op(spac_pkg::OP_CHECK, 32'd6, 3'd4, 1'b0);            // clean across shadow bytes
        push_op(spac_pkg::OP_CHECK, 32'd7, 3'd4, 1'b1);            // byte 10 poisoned, crosses
        push_op(spac_pkg::OP_POISON, 32'd8, 3'd1, 1'b0);
        push_op(spac_pkg::OP_CHECK, 32'd6, 3'd3, 1'b1);            // hits re-poisoned byte 8
        push_op(spac_pkg::OP_CHECK, 32'd4, 3'd0, 1'b0);            // size 0 acts as 1
        push_op(spac_pkg::OP_CHECK, 32'd4, 3'd7, 1'b0);            // size 7 acts as 4, clean
        push_op(spac_pkg::OP_CHECK, 32'd6, 3'd7, 1'b1);            // size 7 reported as 4
        push_op(OP_UNUSED, 32'd4, 3'd4, 1'b1);                     // no-op, all-zero result
        push_op(spac_pkg::OP_CHECK, REGION_BYTES - 1, 3'd1, 1'b0); // last byte, still poisoned
        push_op(spac_pkg::OP_CHECK, REGION_BYTES - 3, 3'd4, 1'b0); // runs past the end
        push_op(spac_pkg::OP_CHECK, REGION_BYTES - 4, 3'd4, 1'b1); // just fits
        push_op(spac_pkg::OP_CLEAR, REGION_BYTES, 3'd1, 1'b0);     // first byte past the end
        push_op(spac_pkg::OP_POISON, REGION_BYTES - 1, 3'd4, 1'b0); // mark ignores size
        push_op(spac_pkg::OP_POISON, 32'hFFFF_FFFF, 3'd1, 1'b1);
        push_op(spac_pkg::OP_CHECK, 32'hFFFF_FFFF, 3'd4, 1'b1);    // offset + size wraps 32 bits
        push_op(spac_pkg::OP_CLEAR, REGION_BYTES - 1, 3'd3, 1'b0);
        push_op(spac_pkg::OP_CHECK, REGION_BYTES - 1, 3'd1, 1'b1); // now clean
    endtask

    // Mostly clear/poison/check traffic in a small window so that checks see
    // a mix of clean and poisoned bytes; the rest hits the region edges or
    // is full-range noise.
    task automatic run_random(input int count);
        int                          pick;
        logic [spac_pkg::ADDR_W-1:0] offset;
        logic [1:0]                  op;
        logic [spac_pkg::SIZE_W-1:0] size;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(63) == 0) begin
                pick = $urandom_range(9);
                win_offset = (pick == 0) ? 0 :
                             (pick == 1) ? REGION_BYTES - 64 :
                             $urandom_range(REGION_BYTES - 64);
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                // noise: any op code, any size code, any address
                push_op(2'($urandom_range(3)), $urandom(), 3'($urandom_range(7)),
                        1'($urandom_range(1)));
                continue;
            end
            if (pick < 14)      offset = REGION_BYTES - 1 - $urandom_range(5);
            else if (pick < 18) offset = 32'd0 - $urandom_range(1, 4);
            else                offset = win_offset + $urandom_range(63);
            pick = $urandom_range(99);
            op   = (pick < 48) ? spac_pkg::OP_CHECK : (pick < 78) ? spac_pkg::OP_CLEAR :
                   (pick < 97) ? spac_pkg::OP_POISON : OP_UNUSED;
            size = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
            push_op(op, tracker.region_base + offset, size, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: sender idles a little, receiver a lot
        src_idle_pct  = 16;
        sink_idle_pct = 77;
        write_region_base(32'd0);
        run_directed();
        run_random(300);
        write_region_base(32'hFFFF_FFFF);   // region wraps past the top of memory
        run_random(130);

        // Phase 2: roles swapped
        src_idle_pct  = 77;
        sink_idle_pct = 16;
        write_region_base($urandom());
        run_random(420);

        // Phase 3: full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_region_base(32'hFFFF_0000);   // region ends at the last address
        run_random(420);

        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0)
            $display("** shadow_poison_access_checker: PASSED **");
        else
            $display("** shadow_poison_access_checker: FAILED **");
        $finish;
    end

endmodule
